// ===== src/gmv_pkg.sv =====
package gmv_pkg;

  // Grid geometry and cell state width
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int STATE_BITS = 2;

  localparam int NUM_VALUES = 1 << STATE_BITS;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int BANK_AW    = ROW_W + COL_W;
  localparam int RAM_AW     = BANK_AW + 1;
  localparam int CNT_W      = 4;

  // Field and register widths
  localparam int ACT_W      = 2;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 2;
  localparam int DIM_W      = 7;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int DIV_STEPS  = IDX_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // Configuration port
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_NBHD  = 2'd2;
  localparam logic [1:0] REG_BOUND = 2'd3;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UPDATE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  // Neighbour offset codes along one axis
  localparam logic [1:0] OFS_MINUS = 2'd0;
  localparam logic [1:0] OFS_ZERO  = 2'd1;
  localparam logic [1:0] OFS_PLUS  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] cell_index;
    logic [VAL_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic [IDX_W-1:0] result_index;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_GATHER,
    S_DRAIN,
    S_WRITE
  } state_t;

endpackage

// ===== src/grid_majority_vote_step_top.sv =====
// Majority-vote cell update engine over two banks of a 64 x 64 grid of 2-bit
// cells. Raise start with in_item while busy is low; the item is taken at that
// edge. Load, advance and ignored items (unknown action, index outside the
// grid) are handled in the decode state alone. An update steps through decode,
// the bit-serial row/column divider (one quotient bit per cycle over the 12-bit
// index), neighbour reads through the single read port of the cell memory, a
// drain of the last read into the counters and the write of the winner into the
// next bank. The result appears on out_item with out_valid for exactly one
// cycle, in the same cycle that busy falls; there is no backpressure, so the
// receiver must take every beat.
// Grid cells have no reset: load every cell an update will read first.
module grid_majority_vote_step_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  gmv_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output gmv_pkg::out_item_t           out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gmv_pkg::APB_AW-1:0]   paddr,
  input  logic [gmv_pkg::APB_DW-1:0]   pwdata,
  output logic [gmv_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  import gmv_pkg::*;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic              bank_r;
  logic [DIM_W-1:0]  rows_r, cols_r;
  logic              moore_r, cutoff_r;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic [1:0]        dr_r, dc_r;
  logic              inc_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              accept, cfg_wr;
  logic [1:0]        reg_idx;
  logic              in_range;
  logic              div_start, div_done;
  logic [IDX_W-1:0]  div_quo;
  logic [DIM_W-1:0]  div_rem;
  logic [ROW_W-1:0]  cur_row, nb_row;
  logic [COL_W-1:0]  cur_col, nb_col;
  logic              row_ok, col_ok, nb_use;
  logic [BANK_AW-1:0] nb_addr;
  logic              last_nb;
  logic              tally_clear;
  logic [STATE_BITS-1:0] rd_value, best;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [STATE_BITS-1:0] ram_wdata;
  logic              emit, toggle_bank;

  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(64);
      cols_r   <= DIM_W'(64);
      moore_r  <= 1'b0;
      cutoff_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROWS:  rows_r   <= pwdata[DIM_W-1:0];
        REG_COLS:  cols_r   <= pwdata[DIM_W-1:0];
        REG_NBHD:  moore_r  <= pwdata[0];
        REG_BOUND: cutoff_r <= pwdata[0];
        default:   ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ROWS:  prdata = APB_DW'(rows_r);
      REG_COLS:  prdata = APB_DW'(cols_r);
      REG_NBHD:  prdata = APB_DW'(moore_r);
      REG_BOUND: prdata = APB_DW'(cutoff_r);
      default:   prdata = '0;
    endcase
  end

  // Clamp grid dimensions into 1..max
  assign rows_eff = (rows_r == '0) ? DIM_W'(1) :
                    (rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_r;
  assign cols_eff = (cols_r == '0) ? DIM_W'(1) :
                    (cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;

  assign in_range = (PROD_W'(item_r.cell_index) <
                     PROD_W'(rows_eff) * PROD_W'(cols_eff));

  // Row and column of the updated cell
  gmv_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (item_r.cell_index),
    .divisor   (cols_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign cur_row = div_quo[ROW_W-1:0];
  assign cur_col = div_rem[COL_W-1:0];

  // Step to the neighbour row, wrapping or dropping at the border
  always_comb begin
    nb_row = cur_row;
    row_ok = 1'b1;
    case (dr_r)
      OFS_MINUS: begin
        if (cur_row == '0) begin
          row_ok = !cutoff_r;
          nb_row = ROW_W'(rows_eff - DIM_W'(1));
        end else begin
          nb_row = cur_row - ROW_W'(1);
        end
      end
      OFS_ZERO: nb_row = cur_row;
      OFS_PLUS: begin
        if (DIM_W'(cur_row) + DIM_W'(1) >= rows_eff) begin
          row_ok = !cutoff_r;
          nb_row = '0;
        end else begin
          nb_row = cur_row + ROW_W'(1);
        end
      end
      default: row_ok = 1'b0;
    endcase
  end

  // Step to the neighbour column, same border rule
  always_comb begin
    nb_col = cur_col;
    col_ok = 1'b1;
    case (dc_r)
      OFS_MINUS: begin
        if (cur_col == '0) begin
          col_ok = !cutoff_r;
          nb_col = COL_W'(cols_eff - DIM_W'(1));
        end else begin
          nb_col = cur_col - COL_W'(1);
        end
      end
      OFS_ZERO: nb_col = cur_col;
      OFS_PLUS: begin
        if (DIM_W'(cur_col) + DIM_W'(1) >= cols_eff) begin
          col_ok = !cutoff_r;
          nb_col = '0;
        end else begin
          nb_col = cur_col + COL_W'(1);
        end
      end
      default: col_ok = 1'b0;
    endcase
  end

  // Skip corners in von Neumann mode
  assign nb_use  = row_ok && col_ok &&
                   (moore_r || dr_r == OFS_ZERO || dc_r == OFS_ZERO);
  assign nb_addr = BANK_AW'(PROD_W'(nb_row) * PROD_W'(cols_eff) + PROD_W'(nb_col));
  assign last_nb = (dr_r == OFS_PLUS) && (dc_r == OFS_PLUS);

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt   = state_r;
    div_start   = 1'b0;
    tally_clear = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = {bank_r, item_r.cell_index[BANK_AW-1:0]};
    ram_wdata   = item_r.cell_value[STATE_BITS-1:0];
    ram_re      = 1'b0;
    emit        = 1'b0;
    toggle_bank = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (item_r.action == ACT_ADVANCE) begin
          toggle_bank = 1'b1;
        end else if (item_r.action == ACT_LOAD && in_range) begin
          ram_we = 1'b1;
        end else if (item_r.action == ACT_UPDATE && in_range) begin
          div_start   = 1'b1;
          tally_clear = 1'b1;
          state_nxt   = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_nxt = S_GATHER;
        end
      end
      S_GATHER: begin
        ram_re = 1'b1;
        if (last_nb) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = {~bank_r, item_r.cell_index[BANK_AW-1:0]};
        ram_wdata = best;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ram_raddr = {bank_r, nb_addr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: bank, neighbour walk, read tag, output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      dr_r        <= OFS_MINUS;
      dc_r        <= OFS_MINUS;
      inc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (toggle_bank) begin
        bank_r <= ~bank_r;
      end
      inc_r       <= ram_re && nb_use;
      out_valid_r <= emit;
      if (state_r == S_GATHER) begin
        if (dc_r == OFS_PLUS) begin
          dc_r <= OFS_MINUS;
          dr_r <= last_nb ? OFS_MINUS : dr_r + 2'd1;
        end else begin
          dc_r <= dc_r + 2'd1;
        end
      end
    end
  end

  // Hold the accepted item and the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (emit) begin
      out_item_r.new_value    <= VAL_W'(best);
      out_item_r.result_index <= item_r.cell_index;
    end
  end

  gmv_cell_ram #(
    .ADDR_W (RAM_AW),
    .DATA_W (STATE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_value)
  );

  gmv_tally u_tally (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (tally_clear),
    .inc   (inc_r),
    .value (rd_value),
    .best  (best)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result beat follows only the write-back cycle
  a_out_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_WRITE)
    else $error("result beat without write-back");

  // An accepted item is decoded in the next cycle
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DECODE)
    else $error("accepted item not decoded");

  // The divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVIDE)
    else $error("divider done outside divide phase");

  // The result carries the index of the item in flight
  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.result_index == item_r.cell_index)
    else $error("result index mismatch");

endmodule

// ===== src/gmv_cell_ram.sv =====
module gmv_cell_ram #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 2
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gmv_divider.sv =====
module gmv_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gmv_pkg::IDX_W-1:0]  dividend,
  input  logic [gmv_pkg::DIM_W-1:0]  divisor,
  output logic                       done,
  output logic [gmv_pkg::IDX_W-1:0]  quotient,
  output logic [gmv_pkg::DIM_W-1:0]  remainder
);

  import gmv_pkg::*;

  logic [DIM_W-1:0]  rem_r;
  logic [IDX_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DIM_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[IDX_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= fits ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
      quo_r <= {quo_r[IDX_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== src/gmv_tally.sv =====
module gmv_tally (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic                            inc,
  input  logic [gmv_pkg::STATE_BITS-1:0]  value,
  output logic [gmv_pkg::STATE_BITS-1:0]  best
);

  import gmv_pkg::*;

  logic [CNT_W-1:0] hist_r [NUM_VALUES];
  logic [CNT_W-1:0] best_cnt;

  // Count each neighbour state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_VALUES; k++) begin
        hist_r[k] <= '0;
      end
    end else if (clear) begin
      for (int k = 0; k < NUM_VALUES; k++) begin
        hist_r[k] <= '0;
      end
    end else if (inc) begin
      hist_r[value] <= hist_r[value] + CNT_W'(1);
    end
  end

  // Pick the highest count, smallest value on a tie
  always_comb begin
    best     = '0;
    best_cnt = hist_r[0];
    for (int k = 1; k < NUM_VALUES; k++) begin
      if (hist_r[k] > best_cnt) begin
        best     = STATE_BITS'(k);
        best_cnt = hist_r[k];
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import gmv_pkg::*;

  // Action 3 has no meaning; the block must drop it
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  localparam int BANK_CELLS    = MAX_ROWS * MAX_COLS;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TARGET_ITEMS  = 800;
  localparam int MAX_GAP       = 18;

  typedef int unsigned cell_list_t[$];

  // Mirror of the grid banks and registers; predicts every vote
  class grid_vote_tracker;
    logic [VAL_W-1:0] cells [2*BANK_CELLS];
    bit               written [2*BANK_CELLS];
    bit               bank;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    bit               moore;
    bit               cutoff;
    out_item_t        pending_votes[$];
    int               failures;

    function new();
      bank     = 1'b0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      moore    = 1'b0;
      cutoff   = 1'b0;
      failures = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned eff_rows();
      return clamp_dim(rows_reg, MAX_ROWS);
    endfunction

    function int unsigned eff_cols();
      return clamp_dim(cols_reg, MAX_COLS);
    endfunction

    function bit in_grid(int unsigned idx);
      return idx < eff_rows() * eff_cols();
    endfunction

    function bit is_loaded(int unsigned idx);
      return written[int'(bank) * BANK_CELLS + idx];
    endfunction

    // Move one step along an axis; return 0 when the step leaves a cutoff grid
    function bit step_axis(int unsigned pos, int d, int unsigned size,
                           output int unsigned res);
      res = pos;
      if (d < 0) begin
        if (pos == 0) begin
          if (cutoff) return 0;
          res = size - 1;
        end else begin
          res = pos - 1;
        end
      end else if (d > 0) begin
        if (pos + 1 >= size) begin
          if (cutoff) return 0;
          res = 0;
        end else begin
          res = pos + 1;
        end
      end
      return 1;
    endfunction

    // Collect the neighbourhood of a cell, itself included, repeats kept
    function cell_list_t neighbors(int unsigned idx);
      cell_list_t  list;
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      int unsigned nr;
      int unsigned nc;
      rows = eff_rows();
      cols = eff_cols();
      r = idx / cols;
      c = idx % cols;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (!moore && dr != 0 && dc != 0) continue;
          if (!step_axis(r, dr, rows, nr)) continue;
          if (!step_axis(c, dc, cols, nc)) continue;
          list = {list, nr * cols + nc};
        end
      end
      return list;
    endfunction

    function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      case (addr[APB_AW-1:2])
        REG_ROWS:  rows_reg = data[DIM_W-1:0];
        REG_COLS:  cols_reg = data[DIM_W-1:0];
        REG_NBHD:  moore    = data[0];
        REG_BOUND: cutoff   = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted input beat and queue the vote it causes
    function void take_item(in_item_t it);
      int unsigned hist [NUM_VALUES];
      int unsigned prev;
      int unsigned nxt;
      int unsigned best;
      cell_list_t  list;
      out_item_t   vote;
      prev = int'(bank) * BANK_CELLS;
      nxt  = bank ? 0 : BANK_CELLS;
      case (it.action)
        ACT_ADVANCE: bank = ~bank;
        ACT_LOAD: begin
          if (in_grid(it.cell_index)) begin
            cells[prev + it.cell_index]   = it.cell_value;
            written[prev + it.cell_index] = 1'b1;
          end
        end
        ACT_UPDATE: begin
          if (in_grid(it.cell_index)) begin
            foreach (hist[k]) hist[k] = 0;
            list = neighbors(it.cell_index);
            foreach (list[i]) hist[cells[prev + list[i]]]++;
            // ties fall to the smallest value
            best = 0;
            for (int k = 1; k < NUM_VALUES; k++) begin
              if (hist[k] > hist[best]) best = k;
            end
            cells[nxt + it.cell_index]   = best[VAL_W-1:0];
            written[nxt + it.cell_index] = 1'b1;
            vote.new_value    = best[VAL_W-1:0];
            vote.result_index = it.cell_index;
            pending_votes = {pending_votes, vote};
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest predicted vote
    function void check_vote(out_item_t got);
      out_item_t want;
      if (pending_votes.size() == 0) begin
        $error("unexpected result beat: new_value %0d result_index %0d",
               got.new_value, got.result_index);
        failures++;
        return;
      end
      want = pending_votes.pop_front();
      if (got.new_value !== want.new_value) begin
        $error("new_value: expected %0d, actual %0d", want.new_value, got.new_value);
        failures++;
      end
      if (got.result_index !== want.result_index) begin
        $error("result_index: expected %0d, actual %0d",
               want.result_index, got.result_index);
        failures++;
      end
    endfunction
  endclass

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  grid_vote_tracker  tracker = new();
  int unsigned       items_sent = 0;
  int unsigned       cycles = 0;
  bit                no_gaps = 1'b0;

  grid_majority_vote_step_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Watch every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_vote(out_item);
      if (start && !busy) tracker.take_item(in_item);
      if (psel && penable && pwrite && pready) tracker.write_reg(paddr, pwdata);
    end
  end

  // Drive one input beat after a random gap and hold it until taken
  task automatic send_item(logic [ACT_W-1:0] act, int unsigned idx,
                           logic [VAL_W-1:0] val);
    in_item_t it;
    int       gap;
    it.action     = act;
    it.cell_index = idx[IDX_W-1:0];
    it.cell_value = val;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_ADVANCE || (act != ACT_NOP && tracker.in_grid(it.cell_index)))
      items_sent++;
  endtask

  // Load any unwritten neighbour first, then update the cell
  task automatic vote_at(int unsigned idx);
    cell_list_t list;
    if (tracker.in_grid(idx)) begin
      list = tracker.neighbors(idx);
      foreach (list[i]) begin
        if (!tracker.is_loaded(list[i]))
          send_item(ACT_LOAD, list[i], VAL_W'($urandom_range(0, 3)));
      end
    end
    send_item(ACT_UPDATE, idx, VAL_W'($urandom_range(0, 3)));
  endtask

  // Drop start and wait until the block has nothing in flight
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_votes.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int unsigned rows, int unsigned cols, bit nbhd, bit bound);
    settle();
    reg_write(REG_ROWS, rows);
    reg_write(REG_COLS, cols);
    reg_write(REG_NBHD, APB_DW'(nbhd));
    reg_write(REG_BOUND, APB_DW'(bound));
  endtask

  // Mostly tiny grids, now and then an extreme register value
  function automatic int unsigned pick_dim();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 8);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return MAX_ROWS;
      3: return 127;
      default: return $urandom_range(1, MAX_ROWS);
    endcase
  endfunction

  initial begin
    int unsigned cells_in;
    int unsigned roll;
    int unsigned ops;
    int unsigned drain;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: full grid, five cells, wraparound at the far corner
    send_item(ACT_LOAD, 4095, 3);
    vote_at(4095);

    // One-cell wrapped grid: the cell sees itself nine times
    configure(1, 1, 1, 0);
    send_item(ACT_LOAD, 0, 3);
    vote_at(0);
    send_item(ACT_UPDATE, 1, 0);
    send_item(ACT_NOP, 0, 1);
    send_item(ACT_ADVANCE, 0, 0);
    vote_at(0);

    // Tie between two values: the smaller must win
    configure(3, 3, 0, 0);
    send_item(ACT_LOAD, 1, 2);
    send_item(ACT_LOAD, 3, 2);
    send_item(ACT_LOAD, 4, 1);
    send_item(ACT_LOAD, 5, 1);
    send_item(ACT_LOAD, 7, 3);
    send_item(ACT_UPDATE, 4, 0);

    // Clamped sizes with cutoff borders: one row, then one column
    configure(0, 127, 1, 1);
    vote_at(63);
    send_item(ACT_LOAD, 64, 2);
    configure(127, 0, 0, 1);
    vote_at(0);

    // Random phases, each under its own settings
    while (items_sent < TARGET_ITEMS) begin
      configure(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      no_gaps  = ($urandom_range(0, 3) == 0);
      cells_in = tracker.eff_rows() * tracker.eff_cols();
      ops      = $urandom_range(20, 60);
      repeat (ops) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          vote_at($urandom_range(0, cells_in - 1));
        end else if (roll < 80) begin
          send_item(ACT_LOAD, $urandom_range(0, cells_in - 1),
                    VAL_W'($urandom_range(0, 3)));
        end else if (roll < 88) begin
          send_item(ACT_ADVANCE, $urandom_range(0, 4095), VAL_W'($urandom_range(0, 3)));
        end else if (roll < 94) begin
          send_item(ACT_NOP, $urandom_range(0, 4095), VAL_W'($urandom_range(0, 3)));
        end else if (cells_in < 4096) begin
          // index past the grid: load or update must be dropped
          send_item($urandom_range(0, 1) ? ACT_UPDATE : ACT_LOAD,
                    $urandom_range(cells_in, 4095), VAL_W'($urandom_range(0, 3)));
        end else begin
          vote_at($urandom_range(0, 4095));
        end
      end
    end

    // Drain remaining votes, then let the block go quiet
    @(negedge clk);
    start <= 1'b0;
    drain = 0;
    while ((tracker.pending_votes.size() != 0 || busy) && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.pending_votes.size() != 0) begin
      $error("%0d predicted votes never arrived", tracker.pending_votes.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
